### rtl/dlls_pkg.sv
// Shared types and codes for the doubly linked list store unit.
// No dependencies; imported by rtl/doubly_linked_list_store_unit.sv.
package dlls_pkg;

    typedef enum logic [2:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_BACK  = 3'd1,
        REQ_DELETE    = 3'd2,
        REQ_DUMP_FWD  = 3'd3,
        REQ_DUMP_REV  = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] item_value;
        logic               is_last;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_NODE,
        S_INS_LINK,
        S_DEL_HEAD,
        S_DEL_TAIL,
        S_DEL_WALK,
        S_UNL_PREV,
        S_UNL_NEXT,
        S_DUMP,
        S_STATUS
    } state_t;

endpackage

### rtl/doubly_linked_list_store_unit.sv
// Bounded doubly linked list of signed 32-bit values in a node memory.
// Depends on rtl/dlls_pkg.sv (payload structs, request/status codes, states).
//
// Usage:
//   s_ channel carries one request per transaction: insert front/back,
//   delete by key, dump forward/reverse. Codes 5..7 are dropped silently.
//   m_ channel returns results: one status per insert or delete; a dump
//   returns one transaction per entry (is_last on the final one) or a single
//   list-empty status.
//   One request is in work at a time; s_ready is high only while idle.
//   A delete compares the head, then the tail, then one walked node after
//   another (at most DEPTH + 1 nodes compared). Delete and dump speed
//   is set by the single read port of the node memory: one node per cycle,
//   with a dump holding while the receiver stalls m_.
//   A result register sits on m_; a stalled receiver holds the sequencer
//   only in states that emit, and the unit may take a new request while
//   the last result is still waiting.
//   Reset (aresetn low, synchronous) empties the list and frees all slots;
//   node memory contents are not cleared and need no clearing pass.
module doubly_linked_list_store_unit #(
    parameter int DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dlls_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dlls_pkg::out_item_t m_data
);
    import dlls_pkg::*;

    localparam int IDX_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LNK_W  = 2 * IDX_W;
    localparam logic [IDX_W-1:0] NIL = IDX_W'(DEPTH);

    // node memories: value, and {next, prev} links
    logic signed [31:0] val_mem [DEPTH];
    logic [LNK_W-1:0]   lnk_mem [DEPTH];

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]   tail_reg, tail_next;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic [DEPTH-1:0]   free_reg, free_next;
    logic signed [31:0] key_reg, key_next;
    logic               dir_reg, dir_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [IDX_W-1:0]   lp_reg, lp_next;
    logic [IDX_W-1:0]   lq_reg, lq_next;
    logic [IDX_W-1:0]   un_reg, un_next;
    status_t            status_reg, status_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    // memory port controls
    logic               rd_en;
    logic [IDX_W-1:0]   rd_idx;
    logic               val_we;
    logic               lk_we_n, lk_we_p;
    logic [IDX_W-1:0]   lk_idx;
    logic [IDX_W-1:0]   lk_wd_n, lk_wd_p;
    logic signed [31:0] val_q;
    logic [LNK_W-1:0]   lnk_q;

    logic               acc;
    logic               out_free;
    logic               is_empty;
    logic               is_full;
    logic               hit;
    logic [IDX_W-1:0]   q_nxt, q_prv, dump_nx;
    logic [IDX_W-1:0]   low_free;
    logic [2:0]         req;

    assign s_ready  = (state_reg == S_IDLE);
    assign acc      = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign is_empty = (cnt_reg == '0);
    assign is_full  = (cnt_reg == NIL);
    assign hit      = (val_q == key_reg);
    assign q_nxt    = lnk_q[LNK_W-1:IDX_W];
    assign q_prv    = lnk_q[IDX_W-1:0];
    assign dump_nx  = dir_reg ? q_nxt : q_prv;
    assign req      = s_data.req_type;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // lowest free slot
    always_comb begin
        low_free = NIL;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (free_reg[i]) begin
                low_free = IDX_W'(i);
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (acc) begin
                    case (req)
                        REQ_INS_FRONT, REQ_INS_BACK:
                            state_next = is_full ? S_STATUS : S_INS_NODE;
                        REQ_DELETE:
                            state_next = is_empty ? S_STATUS : S_DEL_HEAD;
                        REQ_DUMP_FWD, REQ_DUMP_REV:
                            state_next = is_empty ? S_STATUS : S_DUMP;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_INS_NODE: state_next = is_empty ? S_STATUS : S_INS_LINK;
            S_INS_LINK: state_next = S_STATUS;
            S_DEL_HEAD: state_next = hit ? S_UNL_PREV : S_DEL_TAIL;
            S_DEL_TAIL: begin
                if (hit) begin
                    state_next = S_UNL_PREV;
                end else if (cur_reg == NIL) begin
                    state_next = S_STATUS;
                end else begin
                    state_next = S_DEL_WALK;
                end
            end
            S_DEL_WALK: begin
                if (hit) begin
                    state_next = S_UNL_PREV;
                end else if (q_nxt == NIL) begin
                    state_next = S_STATUS;
                end
            end
            S_UNL_PREV: state_next = (lq_reg == NIL) ? S_STATUS : S_UNL_NEXT;
            S_UNL_NEXT: state_next = S_STATUS;
            S_DUMP: begin
                if (out_free && dump_nx == NIL) begin
                    state_next = S_IDLE;
                end
            end
            S_STATUS: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        cnt_next     = cnt_reg;
        free_next    = free_reg;
        key_next     = key_reg;
        dir_next     = dir_reg;
        slot_next    = slot_reg;
        cur_next     = cur_reg;
        lp_next      = lp_reg;
        lq_next      = lq_reg;
        un_next      = un_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        rd_en        = 1'b0;
        rd_idx       = head_reg;
        val_we       = 1'b0;
        lk_we_n      = 1'b0;
        lk_we_p      = 1'b0;
        lk_idx       = slot_reg;
        lk_wd_n      = NIL;
        lk_wd_p      = NIL;
        case (state_reg)
            S_IDLE: begin
                if (acc) begin
                    key_next = s_data.value;
                    case (req)
                        REQ_INS_FRONT, REQ_INS_BACK: begin
                            dir_next    = (req == REQ_INS_FRONT);
                            slot_next   = low_free;
                            status_next = is_full ? ST_FULL : ST_OK;
                        end
                        REQ_DELETE: begin
                            status_next = ST_EMPTY;
                            rd_en       = !is_empty;
                            rd_idx      = head_reg;
                        end
                        REQ_DUMP_FWD, REQ_DUMP_REV: begin
                            dir_next    = (req == REQ_DUMP_FWD);
                            status_next = ST_EMPTY;
                            rd_en       = !is_empty;
                            rd_idx      = (req == REQ_DUMP_FWD) ? head_reg : tail_reg;
                        end
                        default: ;
                    endcase
                end
            end
            S_INS_NODE: begin
                val_we  = 1'b1;
                lk_we_n = 1'b1;
                lk_we_p = 1'b1;
                lk_idx  = slot_reg;
                free_next[slot_reg[ADDR_W-1:0]] = 1'b0;
                cnt_next = cnt_reg + 1'b1;
                if (is_empty) begin
                    head_next = slot_reg;
                    tail_next = slot_reg;
                end else if (dir_reg) begin
                    lk_wd_n   = head_reg;
                    cur_next  = head_reg;
                    head_next = slot_reg;
                end else begin
                    lk_wd_p   = tail_reg;
                    cur_next  = tail_reg;
                    tail_next = slot_reg;
                end
            end
            S_INS_LINK: begin
                // hook the old end node to the new one
                lk_idx  = cur_reg;
                lk_we_p = dir_reg;
                lk_we_n = !dir_reg;
                lk_wd_p = slot_reg;
                lk_wd_n = slot_reg;
            end
            S_DEL_HEAD: begin
                if (hit) begin
                    un_next = head_reg;
                    lp_next = q_prv;
                    lq_next = q_nxt;
                end else begin
                    cur_next = q_nxt;
                    rd_en    = 1'b1;
                    rd_idx   = tail_reg;
                end
            end
            S_DEL_TAIL: begin
                if (hit) begin
                    un_next = tail_reg;
                    lp_next = q_prv;
                    lq_next = q_nxt;
                end else if (cur_reg == NIL) begin
                    status_next = ST_NOT_FOUND;
                end else begin
                    rd_en  = 1'b1;
                    rd_idx = cur_reg;
                end
            end
            S_DEL_WALK: begin
                if (hit) begin
                    un_next = cur_reg;
                    lp_next = q_prv;
                    lq_next = q_nxt;
                end else if (q_nxt == NIL) begin
                    status_next = ST_NOT_FOUND;
                end else begin
                    cur_next = q_nxt;
                    rd_en    = 1'b1;
                    rd_idx   = q_nxt;
                end
            end
            S_UNL_PREV: begin
                status_next = ST_OK;
                free_next[un_reg[ADDR_W-1:0]] = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (lp_reg != NIL) begin
                    lk_we_n = 1'b1;
                    lk_idx  = lp_reg;
                    lk_wd_n = lq_reg;
                end else begin
                    head_next = lq_reg;
                end
                if (lq_reg == NIL) begin
                    tail_next = lp_reg;
                end
            end
            S_UNL_NEXT: begin
                lk_we_p = 1'b1;
                lk_idx  = lq_reg;
                lk_wd_p = lp_reg;
            end
            S_DUMP: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.status     = ST_OK;
                    m_data_next.item_value = val_q;
                    m_data_next.is_last    = (dump_nx == NIL);
                    if (dump_nx != NIL) begin
                        rd_en  = 1'b1;
                        rd_idx = dump_nx;
                    end
                end
            end
            S_STATUS: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.status     = status_reg;
                    m_data_next.item_value = '0;
                    m_data_next.is_last    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // node memories, one read port, registered read data
    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_mem[slot_reg[ADDR_W-1:0]] <= key_reg;
        end
        if (lk_we_n) begin
            lnk_mem[lk_idx[ADDR_W-1:0]][LNK_W-1:IDX_W] <= lk_wd_n;
        end
        if (lk_we_p) begin
            lnk_mem[lk_idx[ADDR_W-1:0]][IDX_W-1:0] <= lk_wd_p;
        end
        if (rd_en) begin
            val_q <= val_mem[rd_idx[ADDR_W-1:0]];
            lnk_q <= lnk_mem[rd_idx[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= NIL;
            tail_reg    <= NIL;
            cnt_reg     <= '0;
            free_reg    <= '1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            cnt_reg     <= cnt_next;
            free_reg    <= free_next;
            m_valid_reg <= m_valid_next;
        end
        key_reg    <= key_next;
        dir_reg    <= dir_next;
        slot_reg   <= slot_next;
        cur_reg    <= cur_next;
        lp_reg     <= lp_next;
        lq_reg     <= lq_next;
        un_reg     <= un_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

endmodule
